// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the grain growth step unit.
// Depends on nothing; a module that includes it provides clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("grain growth assertion failed");
`define GG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grain growth assertion failed");
`define GG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grain growth assertion failed");
`else
`define GG_ASSERT(lbl, prop)
`define GG_ASSERT_IMPL(lbl, ante, cons)
`define GG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/gg_pkg.sv =====
// Package of the grain growth step unit: sizes, codes and shared types.
// Depends on nothing; used by every module of the block.
package gg_pkg;

  localparam int MaxSide   = 64;
  localparam int GrainW    = 16;
  localparam int SideW     = 7;
  localparam int CoordW    = $clog2(MaxSide);
  localparam int AddrW     = 2 * CoordW;
  localparam int Cells     = MaxSide * MaxSide;
  localparam int LineLen   = 2 * MaxSide + 1;
  localparam int TapBottom = 0;
  localparam int TapRight  = MaxSide - 1;
  localparam int TapCenter = MaxSide;
  localparam int TapLeft   = MaxSide + 1;
  localparam int TapTop    = 2 * MaxSide;
  localparam int SweepEnd  = Cells + MaxSide;
  localparam int SweepLast = SweepEnd + 2;
  localparam int SweepW    = $clog2(SweepLast + 1);

  localparam logic [SideW-1:0] SideReset = SideW'(MaxSide);
  localparam logic [SideW-1:0] SideMax   = SideW'(MaxSide);
  localparam logic [SideW-1:0] SideMin   = SideW'(2);

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_READ,
    REQ_STEP,
    REQ_NONE
  } gg_req_e;

  typedef enum logic [1:0] {
    STS_WR_DONE,
    STS_RD_DATA,
    STS_GEN_DONE,
    STS_BAD_COORD
  } gg_status_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_STEP
  } gg_state_e;

  typedef struct packed {
    logic              shift;
    logic [SweepW-1:0] pos;
  } gg_feed_t;

  typedef struct packed {
    logic              en;
    logic [AddrW-1:0]  addr;
    logic [GrainW-1:0] data;
  } gg_wr_t;

endpackage

// ===== rtl/core/gg_ram.sv =====
// Single-port-write, single-port-read grid memory with registered read data.
// Depends on gg_pkg for the grid size and cell width.
module gg_ram import gg_pkg::*; (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [GrainW-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [GrainW-1:0] rdata_o
);

  logic [GrainW-1:0] mem_q [Cells];
  logic [GrainW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gg_grow.sv =====
// Neighborhood window and growth decision for one cell per cycle of a sweep.
// Depends on gg_pkg; fed in address order from the current grid memory.
module gg_grow import gg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gg_feed_t          feed_i,
  input  logic [GrainW-1:0] rdata_i,
  input  logic [SideW-1:0]  side_i,
  output gg_wr_t            wr_o
);

  logic [GrainW-1:0] line_q [LineLen];
  logic [AddrW-1:0]  ctr_q;
  logic              ctr_vld_q;
  logic [SweepW-1:0] ctr_full;
  gg_wr_t            wr_q, wr_d;

  logic [CoordW-1:0] row, col;
  logic [SideW-1:0]  last;
  logic              at_top, at_bot, at_lft, at_rgt, in_grid;
  logic [GrainW-1:0] nb_t, nb_r, nb_b, nb_l, center;
  logic [GrainW-1:0] sv [4];
  logic [3:0]        sp;
  logic [2:0]        cnt, best_cnt;
  logic [GrainW-1:0] best;

  assign ctr_full = feed_i.pos - SweepW'(MaxSide);

  always_ff @(posedge clk_i) begin
    if (feed_i.shift) begin
      line_q[0] <= rdata_i;
      for (int i = 1; i < LineLen; i++) begin
        line_q[i] <= line_q[i-1];
      end
      ctr_q <= ctr_full[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_vld_q <= 1'b0;
      wr_q      <= '0;
    end else begin
      ctr_vld_q <= feed_i.shift && (feed_i.pos >= SweepW'(MaxSide));
      wr_q      <= wr_d;
    end
  end

  assign row     = ctr_q[AddrW-1:CoordW];
  assign col     = ctr_q[CoordW-1:0];
  assign last    = side_i - SideW'(1);
  assign at_top  = (row == '0);
  assign at_lft  = (col == '0);
  assign at_bot  = ({1'b0, row} == last);
  assign at_rgt  = ({1'b0, col} == last);
  assign in_grid = ({1'b0, row} < side_i) && ({1'b0, col} < side_i);
  assign nb_t    = line_q[TapTop];
  assign nb_r    = line_q[TapRight];
  assign nb_b    = line_q[TapBottom];
  assign nb_l    = line_q[TapLeft];
  assign center  = line_q[TapCenter];

  always_comb begin
    sp = 4'b0000;
    for (int i = 0; i < 4; i++) begin
      sv[i] = '0;
    end
    if (at_top && at_lft) begin
      sv[0] = nb_r; sv[1] = nb_b; sp = 4'b0011;
    end else if (at_top && at_rgt) begin
      sv[0] = nb_l; sv[1] = nb_b; sp = 4'b0011;
    end else if (at_bot && at_lft) begin
      sv[0] = nb_r; sv[1] = nb_t; sp = 4'b0011;
    end else if (at_bot && at_rgt) begin
      sv[0] = nb_l; sv[1] = nb_t; sp = 4'b0011;
    end else if (at_top) begin
      sv[0] = nb_l; sv[1] = nb_b; sv[2] = nb_r; sp = 4'b0111;
    end else if (at_bot) begin
      sv[0] = nb_l; sv[1] = nb_t; sv[2] = nb_r; sp = 4'b0111;
    end else if (at_lft) begin
      sv[0] = nb_t; sv[1] = nb_b; sv[2] = nb_r; sp = 4'b0111;
    end else if (at_rgt) begin
      sv[0] = nb_b; sv[1] = nb_t; sv[2] = nb_l; sp = 4'b0111;
    end else begin
      sv[0] = nb_t; sv[1] = nb_r; sv[2] = nb_b; sv[3] = nb_l; sp = 4'b1111;
    end
  end

  // The count of a value runs from its first occurrence, so the earliest one wins a tie.
  always_comb begin
    best     = '0;
    best_cnt = '0;
    cnt      = '0;
    for (int k = 0; k < 4; k++) begin
      cnt = '0;
      if (sp[k] && (sv[k] != '0)) begin
        for (int m = k; m < 4; m++) begin
          if (sp[m] && (sv[m] == sv[k])) begin
            cnt = cnt + 3'd1;
          end
        end
        if (cnt > best_cnt) begin
          best_cnt = cnt;
          best     = sv[k];
        end
      end
    end
  end

  always_comb begin
    wr_d.en   = ctr_vld_q;
    wr_d.addr = ctr_q;
    wr_d.data = (!in_grid || (center != '0)) ? center : best;
  end

  assign wr_o = wr_q;

endmodule

// ===== rtl/core/grain_growth_von_neumann_step_unit.sv =====
// Top level of the grain growth step unit: request control, two grid banks, sweep.
// Depends on gg_pkg, gg_ram, gg_grow and assert_macros.svh.
//
//   channel   signals                                      direction
//   in        in_valid_i/in_ready_o, req_type_i, row_i,    input
//             column_i, grain_value_i
//   out       out_valid_o/out_ready_i, reply_value_o,      output
//             reply_status_o
//   cfg       cfg_we_i, cfg_wdata_i (grid_side)            input
//
// After reset a clearing pass zeroes the current bank; no item is taken during it.
// A write or out-of-grid request is answered from idle, an in-grid read via the read state.
// A generation sweeps all 4096 addresses once through the read port plus window fill and
// drain, writing the other bank, which then becomes current. One item is in flight at a
// time; a result waiting in the output register stalls the input.
`include "assert_macros.svh"

module grain_growth_von_neumann_step_unit import gg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] column_i,
  input  logic [GrainW-1:0] grain_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [GrainW-1:0] reply_value_o,
  output logic [1:0]        reply_status_o,
  input  logic              cfg_we_i,
  input  logic [SideW-1:0]  cfg_wdata_i
);

  gg_state_e         state_q, state_d;
  logic [SweepW-1:0] ptr_q, ptr_d;
  logic              sel_q, sel_d;
  logic [SideW-1:0]  side_q;
  logic              out_vld_q, out_vld_d;
  logic [GrainW-1:0] out_value_q, out_value_d;
  gg_status_e        out_status_q, out_status_d;
  gg_feed_t          feed_q, feed_d;

  gg_req_e           req;
  logic              accept, in_grid;
  logic [SideW-1:0]  side_use;
  logic [AddrW-1:0]  addr_in, raddr, waddr;
  logic [GrainW-1:0] wdata, rdata_cur;
  logic [1:0]        ram_we;
  logic [GrainW-1:0] rdata [2];
  gg_wr_t            grow_wr;

  assign req      = gg_req_e'(req_type_i);
  assign addr_in  = {row_i, column_i};
  assign side_use = (side_q < SideMin) ? SideMin : ((side_q > SideMax) ? SideMax : side_q);
  assign in_grid  = ({1'b0, row_i} < side_use) && ({1'b0, column_i} < side_use);
  assign rdata_cur = rdata[sel_q];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    gg_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[b]),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  gg_grow u_grow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .feed_i  (feed_q),
    .rdata_i (rdata_cur),
    .side_i  (side_use),
    .wr_o    (grow_wr)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (ptr_q == SweepW'(Cells - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && (req == REQ_READ) && in_grid) begin
          state_d = S_READ;
        end else if (accept && (req == REQ_STEP)) begin
          state_d = S_STEP;
        end
      end
      S_READ: state_d = S_IDLE;
      S_STEP: begin
        if (ptr_q == SweepW'(SweepLast)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o   = (state_q == S_IDLE) && (!out_vld_q || out_ready_i);
    accept       = in_valid_i && in_ready_o;
    ptr_d        = '0;
    sel_d        = sel_q;
    ram_we       = 2'b00;
    raddr        = addr_in;
    waddr        = addr_in;
    wdata        = grain_value_i;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    feed_d.shift = 1'b0;
    feed_d.pos   = ptr_q;
    case (state_q)
      S_CLEAR: begin
        ram_we[0] = 1'b1;
        waddr     = ptr_q[AddrW-1:0];
        wdata     = '0;
        ptr_d     = ptr_q + SweepW'(1);
      end
      S_IDLE: begin
        if (accept) begin
          case (req)
            REQ_WRITE: begin
              ram_we[sel_q] = in_grid;
              out_vld_d     = 1'b1;
              out_value_d   = '0;
              out_status_d  = in_grid ? STS_WR_DONE : STS_BAD_COORD;
            end
            REQ_READ: begin
              if (!in_grid) begin
                out_vld_d    = 1'b1;
                out_value_d  = '0;
                out_status_d = STS_BAD_COORD;
              end
            end
            REQ_STEP: begin
            end
            default: begin
              out_vld_d    = 1'b1;
              out_value_d  = '0;
              out_status_d = STS_BAD_COORD;
            end
          endcase
        end
      end
      S_READ: begin
        out_vld_d    = 1'b1;
        out_value_d  = rdata_cur;
        out_status_d = STS_RD_DATA;
      end
      S_STEP: begin
        raddr          = ptr_q[AddrW-1:0];
        feed_d.shift   = (ptr_q < SweepW'(SweepEnd));
        ptr_d          = ptr_q + SweepW'(1);
        ram_we[~sel_q] = grow_wr.en;
        waddr          = grow_wr.addr;
        wdata          = grow_wr.data;
        if (ptr_q == SweepW'(SweepLast)) begin
          ptr_d        = '0;
          sel_d        = ~sel_q;
          out_vld_d    = 1'b1;
          out_value_d  = '0;
          out_status_d = STS_GEN_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      ptr_q     <= '0;
      sel_q     <= 1'b0;
      side_q    <= SideReset;
      out_vld_q <= 1'b0;
      feed_q    <= '0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      sel_q     <= sel_d;
      out_vld_q <= out_vld_d;
      feed_q    <= feed_d;
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_vld_q;
  assign reply_value_o  = out_value_q;
  assign reply_status_o = out_status_q;

  `GG_ASSERT(a_one_bank_written, !(ram_we[0] && ram_we[1]))
  `GG_ASSERT_IMPL(a_read_slot_free, state_q == S_READ, !out_vld_q)
  `GG_ASSERT_IMPL(a_no_grow_write_when_ready, in_ready_o, !grow_wr.en)
  `GG_ASSERT_NEXT(a_bank_swap_on_done, (state_q == S_STEP) && (ptr_q == SweepW'(SweepLast)),
                  (sel_q != $past(sel_q)) && out_vld_q)

endmodule
